>>> rtl/iirdf1_pkg.sv
package iirdf1_pkg;

  // Fixed field widths
  localparam int COEF_BITS    = 24;
  localparam int CHANNEL_BITS = 2;
  localparam int REG_IDX_BITS = 3;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_BITS-1:0] REG_B0 = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_B1 = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_B2 = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_A1 = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_A2 = 3'd4;

  // Reset values: b0 is unity at 22 fraction bits, all other taps zero
  localparam logic signed [COEF_BITS-1:0] B0_RESET = 24'sd4194304;
  localparam logic signed [COEF_BITS-1:0] TAP_RESET = 24'sd0;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] b1;
    logic signed [COEF_BITS-1:0] b2;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
  } coef_set_t;

endpackage

>>> rtl/iir_direct_form_one_filter_unit.sv
// Flow: each transfer is held in the input register, then its result in the output register.
// Throughput: one item per cycle while the output is not stalled, any mix of channels; the
//   five tap products and their rounded, saturated sum are logic between the two registers.
// Reset (synchronous, rst high): both registers empty, all channel histories zero,
//   b0 at unity and the other taps at zero.
module iir_direct_form_one_filter_unit #(
  parameter int CHANNELS       = 4,
  parameter int FILTER_ORDER   = 2,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 22
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [iirdf1_pkg::REG_IDX_BITS-1:0]   cfg_index,
  input  logic [iirdf1_pkg::COEF_BITS-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_BITS-1:0]         sample_in,
  input  logic [iirdf1_pkg::CHANNEL_BITS-1:0]   channel_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_BITS-1:0]         sample_out,
  output logic [iirdf1_pkg::CHANNEL_BITS-1:0]   channel_out
);

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_W     = iirdf1_pkg::CHANNEL_BITS;

  iirdf1_pkg::coef_set_t coefs;

  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic [CH_W-1:0]               s1_ch;
  logic [CH_IDX_W-1:0]           s1_idx;
  logic [CH_W-1:0]               ch_mod;
  logic                          advance;
  logic signed [SAMPLE_BITS-1:0] y;

  logic signed [SAMPLE_BITS-1:0] x1_hist [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] x2_hist [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y1_hist [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y2_hist [CHANNELS];

  iirdf1_coef_regs u_coef_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  // Fold the channel number into the configured channel count
  always_comb begin
    ch_mod = channel_in;
    for (int i = 0; i < 3; i++) begin
      if (32'(ch_mod) >= CHANNELS) begin
        ch_mod = ch_mod - CH_W'(CHANNELS);
      end
    end
  end

  // Move on when the result register is free or being emptied
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign s1_idx   = CH_IDX_W'(s1_ch);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x  <= sample_in;
      s1_ch <= ch_mod;
    end
  end

  iirdf1_mac #(
    .FILTER_ORDER   (FILTER_ORDER),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .coefs (coefs),
    .x     (s1_x),
    .x1    (x1_hist[s1_idx]),
    .x2    (x2_hist[s1_idx]),
    .y1    (y1_hist[s1_idx]),
    .y2    (y2_hist[s1_idx]),
    .y     (y)
  );

  // Shift the channel's histories as its result is registered
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        x1_hist[c] <= '0;
        x2_hist[c] <= '0;
        y1_hist[c] <= '0;
        y2_hist[c] <= '0;
      end
    end else if (s1_valid && advance) begin
      x2_hist[s1_idx] <= x1_hist[s1_idx];
      x1_hist[s1_idx] <= s1_x;
      y2_hist[s1_idx] <= y1_hist[s1_idx];
      y1_hist[s1_idx] <= y;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      sample_out  <= y;
      channel_out <= s1_ch;
    end
  end

  // Checks
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input register empty but not ready");

  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(channel_out) < CHANNELS))
    else $error("channel out of range");

  a_result_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> (out_valid && channel_out == $past(s1_ch)))
    else $error("result not registered");

  a_y_hist: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> (y1_hist[$past(s1_idx)] == sample_out))
    else $error("output history differs from emitted sample");

  a_x_hist: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> (x1_hist[$past(s1_idx)] == $past(s1_x)))
    else $error("input history not updated");

endmodule

>>> rtl/iirdf1_coef_regs.sv
module iirdf1_coef_regs (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [iirdf1_pkg::REG_IDX_BITS-1:0]    cfg_index,
  input  logic [iirdf1_pkg::COEF_BITS-1:0]       cfg_data,
  output iirdf1_pkg::coef_set_t                  coefs
);

  // Load the addressed tap; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0 <= iirdf1_pkg::B0_RESET;
      coefs.b1 <= iirdf1_pkg::TAP_RESET;
      coefs.b2 <= iirdf1_pkg::TAP_RESET;
      coefs.a1 <= iirdf1_pkg::TAP_RESET;
      coefs.a2 <= iirdf1_pkg::TAP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        iirdf1_pkg::REG_B0: coefs.b0 <= cfg_data;
        iirdf1_pkg::REG_B1: coefs.b1 <= cfg_data;
        iirdf1_pkg::REG_B2: coefs.b2 <= cfg_data;
        iirdf1_pkg::REG_A1: coefs.a1 <= cfg_data;
        iirdf1_pkg::REG_A2: coefs.a2 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/iirdf1_mac.sv
module iirdf1_mac #(
  parameter int FILTER_ORDER   = 2,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 22
) (
  input  iirdf1_pkg::coef_set_t          coefs,
  input  logic signed [SAMPLE_BITS-1:0]  x,
  input  logic signed [SAMPLE_BITS-1:0]  x1,
  input  logic signed [SAMPLE_BITS-1:0]  x2,
  input  logic signed [SAMPLE_BITS-1:0]  y1,
  input  logic signed [SAMPLE_BITS-1:0]  y2,
  output logic signed [SAMPLE_BITS-1:0]  y
);

  localparam int PROD_W = SAMPLE_BITS + iirdf1_pkg::COEF_BITS;
  // three guard bits cover the sum of five products
  localparam int ACC_W  = PROD_W + 3;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

  logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [ACC_W-1:0]  q;

  // Exact products of each tap
  assign p_b0 = x  * coefs.b0;
  assign p_b1 = x1 * coefs.b1;
  assign p_b2 = x2 * coefs.b2;
  assign p_a1 = y1 * coefs.a1;
  assign p_a2 = y2 * coefs.a2;

  // Sum the taps; second-order taps take part only in a biquad
  always_comb begin
    acc = ACC_W'(p_b0) + ACC_W'(p_b1) - ACC_W'(p_a1);
    if (FILTER_ORDER >= 2) begin
      acc = acc + ACC_W'(p_b2) - ACC_W'(p_a2);
    end
  end

  // Round half up, then floor to an integer sample
  assign acc_rnd = acc + ROUND_HALF;
  assign q       = acc_rnd >>> COEF_FRAC_BITS;

  // Clamp to the sample range
  always_comb begin
    if (q > SAT_MAX) begin
      y = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (q < SAT_MIN) begin
      y = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      y = q[SAMPLE_BITS-1:0];
    end
  end

endmodule
